### rtl/core/unordered_set_round_robin_take_defines.svh
// Assertion macros shared by the checker of the unordered set block.
`ifndef UNORDERED_SET_ROUND_ROBIN_TAKE_DEFINES_SVH
`define UNORDERED_SET_ROUND_ROBIN_TAKE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, idle while i_rst_n is low.
`define USRT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("usrt check failed");

// Next-cycle implication, sampled on i_clk, idle while i_rst_n is low.
`define USRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("usrt check failed");

`endif

### rtl/core/usrt_pkg.sv
// Types and constants for the unordered set with round-robin take.
package usrt_pkg;

    // Operation codes carried on the input tuser
    localparam logic [2:0] K_APPEND   = 3'd0;
    localparam logic [2:0] K_REMOVE   = 3'd1;
    localparam logic [2:0] K_CONTAINS = 3'd2;
    localparam logic [2:0] K_TAKE     = 3'd3;
    localparam logic [2:0] K_CLEAR    = 3'd4;

    // Event codes in the result
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_INSERT = 2'd1;
    localparam logic [1:0] EV_REMOVE = 2'd2;

    localparam int KIND_W   = 3;
    localparam int ITEM_W   = 32;
    localparam int IDX_W    = 4;
    localparam int CURSOR_W = 5;
    localparam int OUT_W    = 40;

    // One result beat before packing
    typedef struct packed {
        logic              ok;
        logic [ITEM_W-1:0] item;
        logic [1:0]        ev;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_result;

    // Request to the cursor modulo unit
    typedef struct packed {
        logic                start;
        logic [CURSOR_W-1:0] cursor;
        logic [CURSOR_W:0]   divisor;
    } t_mod_req;

    // Answer from the cursor modulo unit
    typedef struct packed {
        logic                done;
        logic [CURSOR_W-1:0] rem;
    } t_mod_rsp;

endpackage

### rtl/core/usrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module usrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/usrt_mod.sv
// Iterative cursor-modulo-count unit, one compare and subtract per cycle.
module usrt_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  usrt_pkg::t_mod_req i_req,
    output usrt_pkg::t_mod_rsp o_rsp
);
    import usrt_pkg::*;

    logic                r_busy;
    logic [CURSOR_W-1:0] r_rem;
    logic [CURSOR_W:0]   r_div;
    logic                below;

    assign below = ({1'b0, r_rem} < r_div);

    // Subtract the divisor until the remainder drops below it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_rem  <= i_req.cursor;
            r_div  <= i_req.divisor;
        end else if (r_busy && below) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_rem <= CURSOR_W'({1'b0, r_rem} - r_div);
        end
    end

    assign o_rsp.done = r_busy && below;
    assign o_rsp.rem  = r_rem;

endmodule

### rtl/core/unordered_set_round_robin_take.sv
// Ops run one at a time: append writes one slot; remove/contains scan the slots one by one
// (a remove hit then moves the last entry into the hole); take runs the cursor/count modulo first.
// Clear walks every entry. An op's last result beat goes valid as the input frees up.
// Input accepted whenever the sequencer is idle, even while a result beat waits.
// Reset (synchronous, active low) empties the set and zeroes the cursor; slot RAM
// contents are not cleared, entries at or above the count are never read.
module unordered_set_round_robin_take #(
    parameter int CAPACITY     = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input beat
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] item_handle
    input  logic [2:0]  i_s_axis_tuser,  // [2:0] kind
    // Result beat
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [0] ok, [32:1] out_item, [34:33] event_kind,
                                         // [38:35] event_index, [39] zero
    output logic        o_m_axis_tlast   // last_of_run
);
    import usrt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_MOD      = 3'd3;
    localparam logic [2:0] S_TKRD     = 3'd4;
    localparam logic [2:0] S_FILL     = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;
    localparam logic [2:0] S_CLEAR    = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [KIND_W-1:0]       r_kind, n_kind;
    logic [HANDLE_WIDTH-1:0] r_h, n_h;
    logic [CW-1:0]           r_count, n_count;
    logic [CURSOR_W-1:0]     r_cursor, n_cursor;
    logic [AW-1:0]           r_idx, n_idx;
    logic [HANDLE_WIDTH-1:0] r_item, n_item;
    t_result                 r_res, n_res;
    logic                    r_ovalid;
    t_result                 r_odata;

    logic                    we, re;
    logic [AW-1:0]           waddr, raddr;
    logic [HANDLE_WIDTH-1:0] wdata, rd_data;
    logic [AW-1:0]           last_idx;
    logic                    push, out_load;
    t_mod_req                mod_req;
    t_mod_rsp                mod_rsp;

    // Slot storage
    usrt_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Cursor modulo count
    usrt_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign last_idx = AW'(r_count - CW'(1));
    assign push     = !r_ovalid || i_m_axis_tready;
    assign out_load = (r_state == S_EMIT) && push;

    assign o_s_axis_tready = (r_state == S_IDLE);

    // Sequencer: read, modify, write back one slot access at a time
    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_h      = r_h;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_item   = r_item;
        n_res    = r_res;
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = r_h;
        re       = 1'b0;
        raddr    = '0;
        mod_req.start   = 1'b0;
        mod_req.cursor  = r_cursor;
        mod_req.divisor = (32'(r_count) > 32) ? 6'd32 : 6'(r_count);

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind  = i_s_axis_tuser;
                    n_h     = HANDLE_WIDTH'(i_s_axis_tdata);
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res      = '0;
                n_res.last = 1'b1;
                n_state    = S_EMIT;
                case (r_kind)
                    K_APPEND: begin
                        if (r_count != CW'(CAPACITY)) begin
                            we        = 1'b1;
                            waddr     = AW'(r_count);
                            wdata     = r_h;
                            n_count   = r_count + CW'(1);
                            n_res.ok  = 1'b1;
                            n_res.ev  = EV_INSERT;
                            n_res.idx = IDX_W'(r_count);
                        end
                    end
                    K_REMOVE, K_CONTAINS: begin
                        if (r_count != '0) begin
                            re      = 1'b1;
                            raddr   = '0;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    K_TAKE: begin
                        if (r_count != '0) begin
                            mod_req.start = 1'b1;
                            n_state       = S_MOD;
                        end
                    end
                    K_CLEAR: begin
                        if (r_count == '0) begin
                            n_cursor = '0;
                            n_res.ok = 1'b1;
                        end else begin
                            re      = 1'b1;
                            raddr   = '0;
                            n_state = S_CLEAR;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (rd_data == r_h) begin
                    if (r_kind == K_REMOVE) begin
                        // Hit: fetch the last entry to fill the hole
                        n_item  = rd_data;
                        re      = 1'b1;
                        raddr   = last_idx;
                        n_state = S_FILL;
                    end else begin
                        n_res.ok = 1'b1;
                        n_state  = S_EMIT;
                    end
                end else if (r_idx == last_idx) begin
                    n_state = S_EMIT;
                end else begin
                    re    = 1'b1;
                    raddr = r_idx + AW'(1);
                    n_idx = r_idx + AW'(1);
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    n_idx   = AW'(mod_rsp.rem);
                    re      = 1'b1;
                    raddr   = AW'(mod_rsp.rem);
                    n_state = S_TKRD;
                end
            end
            S_TKRD: begin
                n_item  = rd_data;
                re      = 1'b1;
                raddr   = last_idx;
                n_state = S_FILL;
            end
            S_FILL: begin
                // Last entry moves into the hole
                we         = 1'b1;
                waddr      = r_idx;
                wdata      = rd_data;
                n_count    = r_count - CW'(1);
                n_res.ok   = 1'b1;
                n_res.item = ITEM_W'(r_item);
                n_res.ev   = EV_REMOVE;
                n_res.idx  = IDX_W'(r_idx);
                n_res.last = 1'b1;
                if (r_kind == K_TAKE) begin
                    n_cursor = CURSOR_W'(32'(r_idx) + 1);
                end
                n_state = S_EMIT;
            end
            S_CLEAR: begin
                n_res.ok   = 1'b1;
                n_res.item = ITEM_W'(rd_data);
                n_res.ev   = EV_REMOVE;
                n_res.idx  = '0;
                n_res.last = (r_count == CW'(1));
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (push) begin
                    if (r_kind == K_CLEAR && r_res.ev == EV_REMOVE) begin
                        // Clear walks slot 0, then the tail downward
                        n_count = r_count - CW'(1);
                        if (r_res.last) begin
                            n_cursor = '0;
                            n_state  = S_IDLE;
                        end else begin
                            re      = 1'b1;
                            raddr   = last_idx;
                            n_state = S_CLEAR;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    // Per-op payload
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_h    <= n_h;
        r_idx  <= n_idx;
        r_item <= n_item;
        r_res  <= n_res;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_odata.idx, r_odata.ev, r_odata.item, r_odata.ok};
    assign o_m_axis_tlast  = r_odata.last;

endmodule

### rtl/core/usrt_checker.sv
// Port-level checker for the unordered set block, bound to the top level.
`include "unordered_set_round_robin_take_defines.svh"

module usrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic [2:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    import usrt_pkg::*;

    logic [1:0] ev;
    logic       ok;
    logic       item_zero;
    logic       busy_in;

    assign ev        = o_m_axis_tdata[34:33];
    assign ok        = o_m_axis_tdata[0];
    assign item_zero = (o_m_axis_tdata[32:1] == '0);
    assign busy_in   = i_s_axis_tvalid && o_s_axis_tready;

    // A stalled beat stays up
    `USRT_ASSERT_NEXT(a_hold_valid, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    // An insert carries success and no handle
    `USRT_ASSERT_NOW(a_insert_shape, o_m_axis_tvalid && ev == EV_INSERT, ok && item_zero)
    // A removal always reports success
    `USRT_ASSERT_NOW(a_remove_ok, o_m_axis_tvalid && ev == EV_REMOVE, ok)
    // No event means no handle and index zero
    `USRT_ASSERT_NOW(a_none_shape, o_m_axis_tvalid && ev == EV_NONE,
                     item_zero && o_m_axis_tdata[38:35] == '0)
    // The sequencer leaves idle right after taking a beat
    `USRT_ASSERT_NEXT(a_one_at_a_time, busy_in, !o_s_axis_tready)

endmodule

bind unordered_set_round_robin_take usrt_checker u_usrt_checker (.*);
